>>> rtl/core/pwmdw_pkg.sv
`default_nettype none

package pwmdw_pkg;

  localparam int TIME_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int CORR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int DUTY_BITS_DEF   = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [CORR_W-1:0]    CORR_RST    = 8'd20;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR    = 2'd1;

endpackage

`default_nettype wire

>>> rtl/core/pwm_duty_window_meter.sv
// Flow: an item that opens the window or leaves it open updates registered state; an item
//   that closes it steps through ST_CORR and ST_PREP, then, if both counts are nonzero,
//   ST_DIV (restoring divider, one quotient bit per cycle) and ST_DONE, which waits while
//   the previous result is still held on the output. Throughput: one item per cycle while
//   capturing; no new item is accepted until the block is back in ST_IDLE.
// Reset: rst_ni asynchronous, active low; window closed, counts zero, registers at defaults.
`default_nettype none

module pwm_duty_window_meter #(
  parameter int COUNT_WIDTH = pwmdw_pkg::COUNT_WIDTH_DEF,
  parameter int DUTY_BITS   = pwmdw_pkg::DUTY_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [pwmdw_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [pwmdw_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // sample_level [0], time_ms [32:1], zero padding above
  input  wire logic [((pwmdw_pkg::TIME_W+1+7)/8)*8-1:0] s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // duty_fraction, then high_samples, then low_samples, zero padding above
  output logic [((DUTY_BITS+2*COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import pwmdw_pkg::*;

  localparam int OutW  = ((DUTY_BITS + 2*COUNT_WIDTH + 7) / 8) * 8;
  localparam int DenW  = COUNT_WIDTH + 1;
  localparam int CntW  = $clog2(DUTY_BITS);
  localparam int PadW  = OutW - DUTY_BITS - 2*COUNT_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic                   capturing_q, capturing_d;
  logic [COUNT_WIDTH-1:0] high_q, high_d;
  logic [COUNT_WIDTH-1:0] low_q, low_d;
  logic [TIME_W-1:0]      start_q, start_d;
  logic [TIMEOUT_W-1:0]   timeout_q, timeout_d;
  logic [CORR_W-1:0]      corr_q, corr_d;
  logic [DenW-1:0]        den_q, den_d;
  logic [DenW-1:0]        rem_q, rem_d;
  logic [DUTY_BITS-1:0]   quot_q, quot_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   m_valid_q, m_valid_d;
  logic [DUTY_BITS-1:0]   o_duty_q, o_duty_d;
  logic [COUNT_WIDTH-1:0] o_high_q, o_high_d;
  logic [COUNT_WIDTH-1:0] o_low_q, o_low_d;

  logic                   in_level;
  logic [TIME_W-1:0]      in_time;
  logic [TIME_W-1:0]      elapsed;
  logic [DenW:0]          rem_sh;
  logic                   rem_ge;
  logic [COUNT_WIDTH-1:0] corr_ext;
  logic                   high_max, low_max;

  assign in_level = s_axis_tdata[0];
  assign in_time  = s_axis_tdata[TIME_W:1];
  assign elapsed  = in_time - start_q;
  assign corr_ext = COUNT_WIDTH'(corr_q);
  assign high_max = &high_q;
  assign low_max  = &low_q;

  // restoring divider step
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, o_low_q, o_high_q, o_duty_q};

  always_comb begin
    state_d     = state_q;
    capturing_d = capturing_q;
    high_d      = high_q;
    low_d       = low_q;
    start_d     = start_q;
    timeout_d   = timeout_q;
    corr_d      = corr_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    o_duty_d    = o_duty_q;
    o_high_d    = o_high_q;
    o_low_d     = o_low_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMEOUT: timeout_d = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_CORR:    corr_d    = cfg_wdata_i[CORR_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (!capturing_q) begin
            low_d = '0;
            if (in_level) begin
              capturing_d = 1'b1;
              high_d      = COUNT_WIDTH'(1);
              start_d     = in_time;
            end else begin
              high_d = '0;
            end
          end else begin
            if (in_level) begin
              if (!high_max) high_d = high_q + COUNT_WIDTH'(1);
            end else begin
              if (!low_max) low_d = low_q + COUNT_WIDTH'(1);
            end
            if (elapsed >= TIME_W'(timeout_q)) begin
              capturing_d = 1'b0;
              state_d     = ST_CORR;
            end
          end
        end
      end
      ST_CORR: begin
        // correction clamps at zero
        low_d   = (low_q > corr_ext) ? low_q - corr_ext : '0;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        if ((high_q == '0) || (low_q == '0)) begin
          state_d = ST_IDLE;
        end else begin
          den_d   = DenW'(high_q) + DenW'(low_q);
          rem_d   = DenW'(high_q);
          quot_d  = '0;
          cnt_d   = CntW'(DUTY_BITS - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_d = DenW'(rem_sh - {1'b0, den_q});
        end else begin
          rem_d = rem_sh[DenW-1:0];
        end
        quot_d = {quot_q[DUTY_BITS-2:0], rem_ge};
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          o_duty_d  = quot_q;
          o_high_d  = high_q;
          o_low_d   = low_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      capturing_q <= 1'b0;
      high_q      <= '0;
      low_q       <= '0;
      start_q     <= '0;
      timeout_q   <= TIMEOUT_RST;
      corr_q      <= CORR_RST;
      cnt_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      capturing_q <= capturing_d;
      high_q      <= high_d;
      low_q       <= low_d;
      start_q     <= start_d;
      timeout_q   <= timeout_d;
      corr_q      <= corr_d;
      cnt_q       <= cnt_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q    <= den_d;
    rem_q    <= rem_d;
    quot_q   <= quot_d;
    o_duty_q <= o_duty_d;
    o_high_q <= o_high_d;
    o_low_q  <= o_low_d;
  end

`ifndef SYNTHESIS
  a_result_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_high_q != '0) && (o_low_q != '0))
    else $error("result with a zero count");

  a_div_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !capturing_q)
    else $error("divider running with window open");

  a_result_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result not loaded from divider");
`endif

endmodule

`default_nettype wire
